// ----- rtl/core/pli_pkg.sv -----
// shared types and constants for the positional list core
// used by pli_cell, the top level and the port checker; no dependencies
`default_nettype none

package pli_pkg;

	// list geometry
	localparam int CAPACITY   = 32;
	localparam int DATA_WIDTH = 32;

	// index of one cell, and a count that can also hold the full capacity
	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);

	// compare width for positions against count + 1
	localparam int CMP_W = (CNT_W + 1 > 7) ? CNT_W + 1 : 7;

	// request codes
	typedef enum logic [2:0] {
		REQ_INS_FIRST = 3'd0,
		REQ_INS_LAST  = 3'd1,
		REQ_INS_AT    = 3'd2,
		REQ_DEL_FIRST = 3'd3,
		REQ_DEL_LAST  = 3'd4,
		REQ_DEL_AT    = 3'd5,
		REQ_DUMP      = 3'd6
	} req_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_BADPOS = 2'd1,
		ST_FULL   = 2'd2,
		ST_EMPTY  = 2'd3
	} status_t;

	// what every cell does on a clock edge
	typedef enum logic [1:0] {
		CELL_HOLD = 2'd0,
		CELL_INS  = 2'd1,
		CELL_DEL  = 2'd2,
		CELL_ROT  = 2'd3
	} cell_op_t;

	// broadcast command to the row of cells
	// idx: insert or delete slot, or last occupied slot for a rotate
	// value: word to insert, or the head word that wraps on a rotate
	typedef struct packed {
		cell_op_t              op;
		logic [IDX_W-1:0]      idx;
		logic [DATA_WIDTH-1:0] value;
	} cell_cmd_t;

endpackage

`default_nettype wire

// ----- rtl/core/pli_cell.sv -----
// one list slot: holds a word and takes its neighbor's word on a shift
// depends on pli_pkg for the command struct and widths
`default_nettype none

module pli_cell import pli_pkg::*; (
	input  wire logic                  clk,
	input  wire cell_cmd_t             cmd,
	input  wire logic [IDX_W-1:0]      cell_idx,
	input  wire logic [DATA_WIDTH-1:0] left_data,
	input  wire logic [DATA_WIDTH-1:0] right_data,
	output logic      [DATA_WIDTH-1:0] data
);

	logic [DATA_WIDTH-1:0] data_q;
	logic [DATA_WIDTH-1:0] data_d;

	// next word for this slot
	always_comb begin
		data_d = data_q;
		unique case (cmd.op)
			CELL_HOLD: data_d = data_q;
			CELL_INS: begin
				if (cell_idx > cmd.idx) begin
					data_d = left_data;
				end else if (cell_idx == cmd.idx) begin
					data_d = cmd.value;
				end
			end
			CELL_DEL: begin
				if (cell_idx >= cmd.idx) begin
					data_d = right_data;
				end
			end
			CELL_ROT: begin
				if (cell_idx < cmd.idx) begin
					data_d = right_data;
				end else if (cell_idx == cmd.idx) begin
					data_d = cmd.value;
				end
			end
			default: data_d = data_q;
		endcase
	end

	// slot storage, payload only
	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	assign data = data_q;

endmodule

`default_nettype wire

// ----- rtl/core/positional_list_insert_delete_core.sv -----
// positional list core: insert and delete results appear in the cycle after the word is taken,
// one request per cycle while the output side keeps up
// a dump request enters the dump state, then its n elements go out one per cycle unless
// stalled, read at the head of the rotating cell row; no request is taken while a dump streams
// async active-low reset empties the list; slot contents are not cleared
// depends on pli_pkg and pli_cell
`default_nettype none

module positional_list_insert_delete_core import pli_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// request channel
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [2:0]  req_type,
	input  wire logic [31:0] item_value,
	input  wire logic [5:0]  position,
	// result channel
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       status,
	output logic [5:0]       element_count,
	output logic [31:0]      read_value,
	output logic             last_result
);

	typedef enum logic {
		S_IDLE,
		S_DUMP
	} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   count_q;
	logic [IDX_W-1:0]   dump_q;
	logic               out_valid_q;
	status_t            status_q;
	logic [5:0]         count_out_q;
	logic [31:0]        read_q;
	logic               last_q;

	logic               out_free;
	logic               accept_in;
	logic [CMP_W-1:0]   pos_w;
	logic [CMP_W-1:0]   cnt_w;
	logic [CNT_W-1:0]   cnt_m1;
	logic [IDX_W-1:0]   last_idx;
	logic [IDX_W-1:0]   pos_idx;
	logic               full;
	logic               empty;
	status_t            st_d;
	logic [CNT_W-1:0]   cnt_d;
	logic [31:0]        cnt_wide;
	logic [31:0]        cnt_cur_wide;
	logic [63:0]        item_wide;
	logic [63:0]        head_wide;
	cell_cmd_t          cmd;

	logic [DATA_WIDTH-1:0] cell_data [CAPACITY];

	// handshake
	always_comb begin
		out_free  = !out_valid_q || !out_stall;
		in_stall  = (state_q == S_DUMP) || !out_free;
		accept_in = in_valid && !in_stall;
	end

	// request decode and cell command
	always_comb begin
		pos_w     = CMP_W'(position);
		cnt_w     = CMP_W'(count_q);
		cnt_m1    = count_q - CNT_W'(1);
		last_idx  = cnt_m1[IDX_W-1:0];
		pos_idx   = IDX_W'(position - 6'd1);
		full      = (count_q == CNT_W'(CAPACITY));
		empty     = (count_q == '0);
		item_wide = 64'(item_value);
		head_wide = 64'(cell_data[0]);
		st_d      = ST_OK;
		cnt_d     = count_q;
		cmd.op    = CELL_HOLD;
		cmd.idx   = '0;
		cmd.value = item_wide[DATA_WIDTH-1:0];

		unique case (req_type)
			REQ_INS_FIRST, REQ_INS_LAST: begin
				if (full) begin
					st_d = ST_FULL;
				end else begin
					cmd.op  = CELL_INS;
					cmd.idx = (req_type == REQ_INS_FIRST) ? '0 : count_q[IDX_W-1:0];
					cnt_d   = count_q + CNT_W'(1);
				end
			end
			REQ_INS_AT: begin
				if (pos_w == '0 || pos_w > cnt_w + CMP_W'(1)) begin
					st_d = ST_BADPOS;
				end else if (full) begin
					st_d = ST_FULL;
				end else begin
					cmd.op  = CELL_INS;
					cmd.idx = pos_idx;
					cnt_d   = count_q + CNT_W'(1);
				end
			end
			REQ_DEL_FIRST, REQ_DEL_LAST: begin
				if (empty) begin
					st_d = ST_EMPTY;
				end else begin
					cmd.op  = CELL_DEL;
					cmd.idx = (req_type == REQ_DEL_FIRST) ? '0 : last_idx;
					cnt_d   = cnt_m1;
				end
			end
			REQ_DEL_AT: begin
				if (empty) begin
					st_d = ST_EMPTY;
				end else if (pos_w == '0 || pos_w > cnt_w) begin
					st_d = ST_BADPOS;
				end else begin
					cmd.op  = CELL_DEL;
					cmd.idx = pos_idx;
					cnt_d   = cnt_m1;
				end
			end
			REQ_DUMP: begin
				st_d = empty ? ST_EMPTY : ST_OK;
			end
			default: st_d = ST_OK;
		endcase

		// no shift unless the word is really taken
		if (!accept_in) begin
			cmd.op = CELL_HOLD;
		end

		// dump rotates the occupied slots by one toward the head
		if (state_q == S_DUMP && out_free) begin
			cmd.op    = CELL_ROT;
			cmd.idx   = last_idx;
			cmd.value = cell_data[0];
		end

		cnt_wide     = 32'(cnt_d);
		// a dump leaves the count alone, whatever waits on the input
		cnt_cur_wide = 32'(count_q);
	end

	// row of cells
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [DATA_WIDTH-1:0] left_w;
		logic [DATA_WIDTH-1:0] right_w;

		if (i == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_mid_l
			assign left_w = cell_data[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_mid_r
			assign right_w = cell_data[i+1];
		end

		pli_cell u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.cell_idx   (IDX_W'(i)),
			.left_data  (left_w),
			.right_data (right_w),
			.data       (cell_data[i])
		);
	end

	// control state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			dump_q      <= '0;
			out_valid_q <= 1'b0;
			status_q    <= ST_OK;
			count_out_q <= '0;
			read_q      <= '0;
			last_q      <= 1'b0;
		end else begin
			if (out_free) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept_in) begin
						if (req_type == REQ_DUMP && !empty) begin
							state_q <= S_DUMP;
							dump_q  <= '0;
						end else begin
							out_valid_q <= 1'b1;
							status_q    <= st_d;
							count_out_q <= cnt_wide[5:0];
							read_q      <= '0;
							last_q      <= 1'b1;
							count_q     <= cnt_d;
						end
					end
				end
				S_DUMP: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						status_q    <= ST_OK;
						count_out_q <= cnt_cur_wide[5:0];
						read_q      <= head_wide[31:0];
						last_q      <= (dump_q == last_idx);
						dump_q      <= dump_q + IDX_W'(1);
						if (dump_q == last_idx) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign element_count = count_out_q;
	assign read_value    = read_q;
	assign last_result   = last_q;

endmodule

`default_nettype wire

// ----- rtl/core/pli_checker.sv -----
// port-level checks for the positional list core, bound to the top level
// depends on pli_pkg and positional_list_insert_delete_core
`default_nettype none

module pli_checker import pli_pkg::*; (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [1:0]  status,
	input wire logic [5:0]  element_count,
	input wire logic [31:0] read_value,
	input wire logic        last_result
);

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(read_value) && $stable(status)
			&& $stable(last_result))
		else $error("result word changed while stalled");

	// count never exceeds the capacity
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> int'(element_count) <= CAPACITY)
		else $error("element count above capacity");

	// only a dump gives more than one word, and those are all ok
	a_multi_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_result |-> status == ST_OK)
		else $error("non-final word with error status");

	// a dump streams without gaps
	a_dump_stream: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_result |=> out_valid)
		else $error("gap inside a dump");

endmodule

bind positional_list_insert_delete_core pli_checker u_pli_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.status        (status),
	.element_count (element_count),
	.read_value    (read_value),
	.last_result   (last_result)
);

`default_nettype wire
